FILE: sv/bat_pkg.sv
// ----------------------------------------------------------------------------
// bat_pkg
// Shared types and constants for the belt activity tray counter.
// ----------------------------------------------------------------------------
package bat_pkg;

    localparam int SAMPLE_W     = 12;
    localparam int RUN_W        = 10;
    localparam int COUNT_W      = 8;

    localparam logic [SAMPLE_W-1:0] FULL_SCALE   = 12'hFFF;
    localparam logic [SAMPLE_W-1:0] THRESH_RESET = 12'd150;
    localparam logic [RUN_W-1:0]    RUN_MAX      = 10'd1023;
    localparam logic [RUN_W-1:0]    COUNT_MAX    = 10'd255;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic en;
        logic first;
    } acc_ctl_t;

endpackage

FILE: sv/bat_cell.sv
// ----------------------------------------------------------------------------
// bat_cell
// One window cell: holds a belt sample and passes it on when enabled.
// ----------------------------------------------------------------------------
module bat_cell
    import bat_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic [SAMPLE_W-1:0] din,
    output logic [SAMPLE_W-1:0] dout
);

    logic [SAMPLE_W-1:0] data_reg;
    logic [SAMPLE_W-1:0] data_next;

    always_comb begin
        data_next = en ? din : data_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            data_reg <= '0;
        end else begin
            data_reg <= data_next;
        end
    end

    assign dout = data_reg;

endmodule

FILE: sv/bat_spread.sv
// ----------------------------------------------------------------------------
// bat_spread
// Running min/max over the samples leaving the end of the cell chain.
// ----------------------------------------------------------------------------
module bat_spread
    import bat_pkg::*;
(
    input  logic                aclk,
    input  acc_ctl_t            ctl,
    input  logic [SAMPLE_W-1:0] din,
    output logic [SAMPLE_W-1:0] lo,
    output logic [SAMPLE_W-1:0] hi
);

    logic [SAMPLE_W-1:0] lo_reg, lo_next;
    logic [SAMPLE_W-1:0] hi_reg, hi_next;

    always_comb begin
        lo_next = lo_reg;
        hi_next = hi_reg;
        if (ctl.en) begin
            if (ctl.first) begin
                lo_next = din;
                hi_next = din;
            end else begin
                if (din < lo_reg) lo_next = din;
                if (din > hi_reg) hi_next = din;
            end
        end
    end

    always_ff @(posedge aclk) begin
        lo_reg <= lo_next;
        hi_reg <= hi_next;
    end

    assign lo = lo_reg;
    assign hi = hi_reg;

endmodule

FILE: sv/belt_activity_tray_counter.sv
// ----------------------------------------------------------------------------
// belt_activity_tray_counter
// Sliding-window belt activity detector with tray run counting.
// ----------------------------------------------------------------------------
// Flow: an input beat is taken only in idle; no new beat is taken until the
//   window scan by the single min/max comparator, one window cell per cycle,
//   is done and the result beat is written.
// Reset: synchronous, active low; window cells cleared to zero, run cleared,
//   threshold set to 150.
module belt_activity_tray_counter
    import bat_pkg::*;
#(
    parameter int WINDOW_LEN     = 10,
    parameter int TICKS_PER_TRAY = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [11:0] cfg_data,     // range_threshold
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,      // [11:0] belt_sample, [23:12] tray_raw
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,      // [0] belt_running, [8:1] tray_count
    output logic [0:0]  m_tuser       // [0] tray_event
);

    localparam int CNT_W = $clog2(WINDOW_LEN);
    localparam int PH_W  = (TICKS_PER_TRAY > 1) ? $clog2(TICKS_PER_TRAY) : 1;

    state_t state_reg, state_next;

    logic [SAMPLE_W-1:0] thresh_reg;
    logic [CNT_W-1:0]    scan_cnt_reg, scan_cnt_next;
    logic                press_nz_reg;
    logic [RUN_W-1:0]    run_reg, run_next;
    logic [RUN_W-1:0]    quot_reg, quot_next;
    logic [PH_W-1:0]     phase_reg, phase_next;

    logic                m_tvalid_reg, m_tvalid_next;
    logic                running_reg;
    logic                event_reg;
    logic [COUNT_W-1:0]  count_reg;

    logic                load, rotate, out_write, scan_last;
    logic                running;
    logic                evt;
    logic [COUNT_W-1:0]  cnt;
    logic [SAMPLE_W-1:0] lo, hi;
    acc_ctl_t            acc_ctl;

    logic [SAMPLE_W-1:0] cell_din [WINDOW_LEN];
    logic [SAMPLE_W-1:0] cell_q   [WINDOW_LEN];

    // ---- window cell chain
    assign load   = s_tvalid && s_tready;
    assign cell_din[0] = load ? s_tdata[11:0] : cell_q[WINDOW_LEN-1];

    genvar g;
    generate
        for (g = 0; g < WINDOW_LEN; g++) begin : g_cell
            if (g > 0) begin : g_link
                assign cell_din[g] = cell_q[g-1];
            end
            bat_cell u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .en      (load || rotate),
                .din     (cell_din[g]),
                .dout    (cell_q[g])
            );
        end
    endgenerate

    // ---- min/max scan
    assign scan_last   = (scan_cnt_reg == CNT_W'(WINDOW_LEN - 1));
    assign acc_ctl.en    = rotate;
    assign acc_ctl.first = (scan_cnt_reg == '0);

    bat_spread u_spread (
        .aclk (aclk),
        .ctl  (acc_ctl),
        .din  (cell_q[WINDOW_LEN-1]),
        .lo   (lo),
        .hi   (hi)
    );

    assign running = ((hi - lo) >= thresh_reg);

    // ---- FSM next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_tvalid) state_next = ST_SCAN;
            ST_SCAN: if (scan_last) state_next = ST_DONE;
            ST_DONE: if (!m_tvalid_reg || m_tready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // ---- FSM outputs
    always_comb begin
        s_tready  = 1'b0;
        rotate    = 1'b0;
        out_write = 1'b0;
        unique case (state_reg)
            ST_IDLE: s_tready  = 1'b1;
            ST_SCAN: rotate    = 1'b1;
            ST_DONE: out_write = !m_tvalid_reg || m_tready;
            default: s_tready  = 1'b0;
        endcase
    end

    always_comb begin
        scan_cnt_next = scan_cnt_reg;
        if (load) begin
            scan_cnt_next = '0;
        end else if (rotate && !scan_last) begin
            scan_cnt_next = scan_cnt_reg + 1'b1;
        end
    end

    // ---- run tracking; quotient kept incrementally
    always_comb begin
        run_next   = run_reg;
        quot_next  = quot_reg;
        phase_next = phase_reg;
        evt        = 1'b0;
        cnt        = '0;
        if (out_write && running) begin
            if (press_nz_reg) begin
                if (run_reg < RUN_MAX) begin
                    run_next = run_reg + 1'b1;
                    if (phase_reg == PH_W'(TICKS_PER_TRAY - 1)) begin
                        phase_next = '0;
                        quot_next  = quot_reg + 1'b1;
                    end else begin
                        phase_next = phase_reg + 1'b1;
                    end
                end
            end else begin
                if (quot_reg != '0) begin
                    evt = 1'b1;
                    cnt = (quot_reg > COUNT_MAX) ? COUNT_MAX[COUNT_W-1:0]
                                                 : quot_reg[COUNT_W-1:0];
                end
                run_next   = '0;
                quot_next  = '0;
                phase_next = '0;
            end
        end
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (out_write) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            thresh_reg   <= THRESH_RESET;
            scan_cnt_reg <= '0;
            run_reg      <= '0;
            quot_reg     <= '0;
            phase_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            scan_cnt_reg <= scan_cnt_next;
            run_reg      <= run_next;
            quot_reg     <= quot_next;
            phase_reg    <= phase_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_valid) begin
                thresh_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            press_nz_reg <= (s_tdata[23:12] != FULL_SCALE);
        end
        if (out_write) begin
            running_reg <= running;
            event_reg   <= evt;
            count_reg   <= cnt;
        end
    end

    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {7'd0, count_reg, running_reg};
    assign m_tuser   = event_reg;

endmodule

FILE: sv/bat_checker.sv
// ----------------------------------------------------------------------------
// bat_checker
// Port-level checks for the belt activity tray counter.
// ----------------------------------------------------------------------------
module bat_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [0:0]  m_tuser
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a sample is in work");

    a_no_evt: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata[8:1] == 8'd0)
        else $error("tray count without event");

    a_evt: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[0] && (m_tdata[8:1] != 8'd0))
        else $error("event on stopped belt or with zero count");

endmodule

bind belt_activity_tray_counter bat_checker u_bat_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

FILE: test/belt_activity_tray_counter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// belt_activity_tray_counter_tb
// Self-checking bench for the belt activity tray counter: a short table of
// belt/tray beats, a long run at zero threshold, then random run/stop/noise
// sequences under several thresholds. Result beats are checked against fixed table
// values or a cycle-free model of the window, run counter and threshold.
// ----------------------------------------------------------------------------
module belt_activity_tray_counter_tb;
    import bat_pkg::*;

    localparam int WIN_LEN        = 10;
    localparam int TICKS_PER_TRAY = 4;
    localparam int CYCLE_LIMIT    = 500000;
    localparam int PHASE_BEATS    = 40;
    localparam int LONG_RUN       = 120;

    typedef struct packed {
        logic       running;
        logic       tray_evt;
        logic [7:0] count;
    } tick_result_t;

    typedef struct {
        logic [11:0]  belt;
        logic [11:0]  tray;
        bit           fixed;
        tick_result_t res;
    } stim_row_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [11:0] cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;    // [11:0] belt_sample, [23:12] tray_raw
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;           // [0] belt_running, [8:1] tray_count
    logic [0:0]  m_tuser;           // [0] tray_event

    // model state
    logic [11:0] belt_hist [WIN_LEN];
    int          hist_slot;
    logic [9:0]  run_ticks;
    logic [11:0] range_thr;

    tick_result_t pending_results[$];
    stim_row_t    directed_rows[$];
    int           errors       = 0;
    int           cycle_count  = 0;
    int           burst_left   = 0;
    int           phase_beats  = 0;

    belt_activity_tray_counter #(
        .WINDOW_LEN     (WIN_LEN),
        .TICKS_PER_TRAY (TICKS_PER_TRAY)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 0;
    end

    function automatic tick_result_t predict_tick(logic [11:0] belt, logic [11:0] tray);
        logic [11:0]  lo;
        logic [11:0]  hi;
        logic [9:0]   trays;
        tick_result_t r;
        int           i;
        belt_hist[hist_slot] = belt;
        hist_slot = (hist_slot == WIN_LEN - 1) ? 0 : hist_slot + 1;
        lo = belt_hist[0];
        hi = belt_hist[0];
        for (i = 1; i < WIN_LEN; i++) begin
            if (belt_hist[i] < lo) lo = belt_hist[i];
            if (belt_hist[i] > hi) hi = belt_hist[i];
        end
        r = '0;
        r.running = ((hi - lo) >= range_thr);
        if (r.running) begin
            if (tray != FULL_SCALE) begin
                if (run_ticks != RUN_MAX) run_ticks = run_ticks + 1'b1;
            end else begin
                if (run_ticks >= TICKS_PER_TRAY) begin
                    trays      = 10'(run_ticks / TICKS_PER_TRAY);
                    r.tray_evt = 1'b1;
                    r.count    = (trays > COUNT_MAX) ? COUNT_MAX[7:0] : trays[7:0];
                end
                run_ticks = '0;
            end
        end
        return r;
    endfunction

    task automatic send_tick(input logic [11:0] belt, input logic [11:0] tray,
                             input bit fixed, input tick_result_t fixed_res);
        tick_result_t r;
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 8);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {tray, belt};
        do @(posedge aclk); while (!s_tready);
        r = predict_tick(belt, tray);
        pending_results.push_back(fixed ? fixed_res : r);
        burst_left--;
        phase_beats++;
    endtask

    task automatic drain_results;
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic write_threshold(input logic [11:0] val);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        range_thr   = val;
        phase_beats = 0;
    endtask

    // run / stopped belt / noise, shaped around the current threshold
    task automatic random_sequence;
        int kind;
        int len;
        int span;
        int lo;
        int level;
        int i;
        kind = $urandom_range(0, 9);
        span = range_thr + $urandom_range(0, 4095 - range_thr);
        lo   = $urandom_range(0, 4095 - span);
        if (kind < 7) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                              : $urandom_range(0, 12);
            for (i = 0; i < len; i++)
                send_tick(12'($urandom_range(0, 1) ? lo + span : lo),
                          12'($urandom_range(0, 4094)), 1'b0, '0);
            send_tick(12'($urandom_range(0, 1) ? lo + span : lo), FULL_SCALE, 1'b0, '0);
        end else if (kind == 7) begin
            level = $urandom_range(0, 4095);
            for (i = 0; i < 12; i++)
                send_tick(12'(level), ($urandom_range(0, 3) == 0) ? FULL_SCALE
                                                    : 12'($urandom_range(0, 4095)),
                          1'b0, '0);
        end else begin
            len = $urandom_range(1, 10);
            for (i = 0; i < len; i++)
                send_tick(12'($urandom_range(0, 4095)),
                          ($urandom_range(0, 3) == 0) ? FULL_SCALE
                                                      : 12'($urandom_range(0, 4095)),
                          1'b0, '0);
        end
    endtask

    // result side: always ready, random, short pattern, long stalls
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            case (cycle_count[10:9])
                2'd0: m_tready <= 1'b1;
                2'd1: m_tready <= ($urandom_range(0, 3) != 0);
                2'd2: m_tready <= ((cycle_count % 11) < 4);
                default: m_tready <= ((cycle_count % 40) >= 30);
            endcase
        end
    end

    always @(posedge aclk) begin
        tick_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result beat with none expected: running=%0b event=%0b count=%0d",
                         $time, m_tdata[0], m_tuser[0], m_tdata[8:1]);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[0] !== want.running) begin
                    $display("%0t: belt_running expected %0b actual %0b",
                             $time, want.running, m_tdata[0]);
                    errors++;
                end
                if (m_tuser[0] !== want.tray_evt) begin
                    $display("%0t: tray_event expected %0b actual %0b",
                             $time, want.tray_evt, m_tuser[0]);
                    errors++;
                end
                if (m_tdata[8:1] !== want.count) begin
                    $display("%0t: tray_count expected %0d actual %0d",
                             $time, want.count, m_tdata[8:1]);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results outstanding", $time, pending_results.size());
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        int          i;
        int          thr_idx;
        logic [11:0] thr_list [5];
        stim_row_t   row;

        foreach (belt_hist[i]) belt_hist[i] = '0;
        hist_slot = 0;
        run_ticks = '0;
        range_thr = THRESH_RESET;

        //                         belt      tray     fixed  running evt count
        directed_rows.push_back('{12'd0,    12'hFFF, 1'b1, '{1'b0, 1'b0, 8'd0}});
        directed_rows.push_back('{12'hFFF,  12'h000, 1'b1, '{1'b1, 1'b0, 8'd0}});
        directed_rows.push_back('{12'hFFF,  12'h000, 1'b1, '{1'b1, 1'b0, 8'd0}});
        // short run: cleared without an event
        directed_rows.push_back('{12'd0,    12'hFFF, 1'b1, '{1'b1, 1'b0, 8'd0}});
        for (i = 0; i < 5; i++)
            directed_rows.push_back('{12'hFFF, 12'h800, 1'b1, '{1'b1, 1'b0, 8'd0}});
        directed_rows.push_back('{12'd0,    12'hFFF, 1'b1, '{1'b1, 1'b1, 8'd1}});
        // flatten the window; belt stops on the last of these
        for (i = 0; i < 10; i++)
            directed_rows.push_back('{12'd2000, 12'd4094, 1'b0, '0});
        // stopped belt keeps the run, then spread equal to threshold ends it
        directed_rows.push_back('{12'd2000, 12'hFFF, 1'b1, '{1'b0, 1'b0, 8'd0}});
        directed_rows.push_back('{12'd2150, 12'hFFF, 1'b1, '{1'b1, 1'b1, 8'd2}});

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            send_tick(row.belt, row.tray, row.fixed, row.res);
        end

        // zero threshold: belt always runs; one long run
        write_threshold(12'd0);
        for (i = 0; i < LONG_RUN; i++)
            send_tick(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4094)), 1'b0, '0);
        send_tick(12'($urandom_range(0, 4095)), FULL_SCALE, 1'b0, '0);

        thr_list[0] = 12'hFFF;
        thr_list[1] = 12'($urandom_range(1, 40));
        thr_list[2] = THRESH_RESET;
        thr_list[3] = 12'($urandom_range(0, 4095));
        thr_list[4] = 12'($urandom_range(100, 2000));
        for (thr_idx = 0; thr_idx < 5; thr_idx++) begin
            write_threshold(thr_list[thr_idx]);
            while (phase_beats < PHASE_BEATS) random_sequence();
        end

        drain_results();
        repeat (WIN_LEN + 8) @(posedge aclk);
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

FILE: belt_activity_tray_counter.f
sv/bat_pkg.sv
sv/bat_cell.sv
sv/bat_spread.sv
sv/belt_activity_tray_counter.sv
sv/bat_checker.sv
test/belt_activity_tray_counter_tb.sv
